FILE: src/text_statistics_counter_defines.svh
// ----------------------------------------------------------------------------
// Text statistics counter - assertion macros
// Property wrappers used by the top-level RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef TEXT_STATISTICS_COUNTER_DEFINES_SVH
`define TEXT_STATISTICS_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define TSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsc assertion failed");

// Next-cycle implication, checked out of reset.
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsc assertion failed");

`else

`define TSC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Text statistics counter - package
// Widths, character codes, item and counter types, classification functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int CNT_W      = 32;
    localparam int RES_W      = 32;
    localparam int NUM_FIELDS = 6;
    localparam int OUT_W      = NUM_FIELDS * RES_W;
    localparam int WIN_LEN    = 10;
    localparam int DOT_POS_A  = 2;
    localparam int DOT_POS_B  = 5;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_FILL    = 8'h78;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUEST   = 8'h3F;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_END  = 1'b1
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] ch;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] number_sum;
        logic [CNT_W-1:0] lines;
        logic [CNT_W-1:0] sentences;
        logic [CNT_W-1:0] numbers;
        logic [CNT_W-1:0] words;
        logic [CNT_W-1:0] characters;
    } t_tally;

    // Index 0 holds the oldest byte.
    typedef logic [WIN_LEN-1:0][7:0] t_window;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return (b == CH_DOT) || (b == CH_BANG) || (b == CH_QUEST);
    endfunction

    // DD.MM.YYYY across the whole window.
    function automatic logic window_is_date(input t_window w);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < WIN_LEN; i++) begin
            if (i == DOT_POS_A || i == DOT_POS_B) begin
                ok = ok & (w[i] == CH_DOT);
            end else begin
                ok = ok & is_digit(w[i]);
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

FILE: src/text_statistics_counter.sv
// ----------------------------------------------------------------------------
// Text statistics counter - top level
// Counts characters, words, numbers, sentences and lines of a byte stream and
// sums its decimal numbers; every item returns a snapshot of all counters.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata                         | tuser
//  --------+-----+-------------------------------+---------------------------
//  s       | in  | [7:0] ch                      | [0] action (1 = end)
//  m       | out | six 32-bit counters, 192 bits | -
//
//  One item per cycle sustained while the output is not stalled; each item passes
//  through the input register, then the update logic into the result register.
//  Reset (synchronous, active low) clears the counters, the scan flags and the
//  date window (filled with 'x'); no clearing pass follows.
//  A stalled output holds its result; the input register still takes one more
//  item, then ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_statistics_counter_defines.svh"

module text_statistics_counter
    import tsc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [7:0]       i_s_tdata,   // [7:0] ch
    input  wire logic             i_s_tuser,   // [0] action
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata    // characters, words, numbers,
                                               // sentences, lines, number_sum
                                               // (32 bits each, lowest first)
);

    logic   r_in_valid;
    t_item  r_in_item;
    logic   r_out_valid;
    t_tally r_out;
    logic   w_adv;
    t_tally w_next;
    t_tally w_cur;

    // Advance the held item into the counters whenever the result slot frees.
    assign w_adv      = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | w_adv;

    // Input register: capture a transfer, drop the item once it advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item <= t_item'({i_s_tuser, i_s_tdata});
        end
    end

    tsc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_item       (r_in_item),
        .o_tally_next (w_next),
        .o_tally_cur  (w_cur)
    );

    // Result register: load the updated counters, hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_next;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {RES_W'(r_out.number_sum), RES_W'(r_out.lines),
                         RES_W'(r_out.sentences),  RES_W'(r_out.numbers),
                         RES_W'(r_out.words),      RES_W'(r_out.characters)};

    // An empty input register always takes a transfer.
    `TSC_ASSERT_SAME(a_in_ready_when_empty, i_clk, i_rst_n, !r_in_valid, o_s_tready)

    // The result register mirrors the counters right after each update.
    `TSC_ASSERT_NEXT(a_result_matches_state, i_clk, i_rst_n, w_adv, r_out == w_cur)

    // A byte adds exactly one character; an end item adds none.
    `TSC_ASSERT_NEXT(a_char_step, i_clk, i_rst_n, w_adv,
        r_out.characters == $past(w_cur.characters)
            + ((($past(r_in_item.action) == ACT_BYTE)) ? CNT_W'(1) : CNT_W'(0)))

endmodule

`default_nettype wire

FILE: src/tsc_core.sv
// ----------------------------------------------------------------------------
// Text statistics counter - update core
// Holds the scan state and the six counters; updates them for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_core
    import tsc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_item  i_item,
    output t_tally      o_tally_next,
    output t_tally      o_tally_cur
);

    logic             r_prev_alnum,   n_prev_alnum;
    logic             r_date_pend,    n_date_pend;
    logic             r_line_alnum,   n_line_alnum;
    logic             r_sent_word,    n_sent_word;
    t_window          r_win,          n_win;
    logic [CNT_W-1:0] r_run_val,      n_run_val;
    logic             r_in_run,       n_in_run;
    t_tally           r_tally,        n_tally;

    logic       w_dig, w_let, w_aln, w_sep, w_word_start, w_sent_mid, w_sent_inc;
    logic [7:0] w_ch;

    assign w_ch  = i_item.ch;
    assign w_dig = is_digit(w_ch);
    assign w_let = is_letter(w_ch);
    assign w_aln = w_dig | w_let;
    assign w_sep = is_sep(w_ch);

    assign w_word_start = ~r_prev_alnum & w_let;
    assign w_sent_mid   = r_sent_word | w_word_start;
    assign w_sent_inc   = w_sent_mid & w_sep;

    always_comb begin
        n_prev_alnum = r_prev_alnum;
        n_date_pend  = r_date_pend;
        n_line_alnum = r_line_alnum;
        n_sent_word  = r_sent_word;
        n_win        = r_win;
        n_run_val    = r_run_val;
        n_in_run     = r_in_run;
        n_tally      = r_tally;

        case (i_item.action)
            ACT_BYTE: begin
                n_tally.characters = r_tally.characters + CNT_W'(1);
                if (w_word_start) begin
                    n_tally.words = r_tally.words + CNT_W'(1);
                end
                if (~r_prev_alnum & w_dig) begin
                    n_tally.numbers = r_tally.numbers + CNT_W'(1);
                end

                // Sentence end and date correction never fire together:
                // one needs a separator, the other a letter.
                n_sent_word = w_sent_inc ? 1'b0 : w_sent_mid;
                if (w_sent_inc) begin
                    n_tally.sentences = r_tally.sentences + CNT_W'(1);
                end else if (r_date_pend & w_let) begin
                    n_tally.sentences = r_tally.sentences - CNT_W'(1);
                end

                n_line_alnum = r_line_alnum | w_aln;
                if (w_ch == CH_NEWLINE) begin
                    if (r_line_alnum) begin
                        n_tally.lines = r_tally.lines + CNT_W'(1);
                    end
                    n_line_alnum = 1'b0;
                end

                if (r_date_pend & (w_sep | w_let)) begin
                    n_date_pend = 1'b0;
                end
                if (window_is_date(r_win)) begin
                    n_date_pend = 1'b1;
                end
                n_win = {w_ch, r_win[WIN_LEN-1:1]};

                // value * 10 + digit as two shifts and adds
                if (w_dig) begin
                    n_run_val = CNT_W'(r_run_val << 3) + CNT_W'(r_run_val << 1)
                              + CNT_W'(w_ch[3:0]);
                    n_in_run  = 1'b1;
                end else if (r_in_run) begin
                    n_tally.number_sum = r_tally.number_sum + r_run_val;
                    n_run_val = '0;
                    n_in_run  = 1'b0;
                end

                n_prev_alnum = w_aln;
            end
            ACT_END: begin
                if (r_line_alnum) begin
                    n_tally.lines = r_tally.lines + CNT_W'(1);
                end
                if (r_sent_word) begin
                    n_tally.sentences = r_tally.sentences + CNT_W'(1);
                end
                if (r_in_run) begin
                    n_tally.number_sum = r_tally.number_sum + r_run_val;
                end
                n_line_alnum = 1'b0;
                n_sent_word  = 1'b0;
                n_in_run     = 1'b0;
                n_run_val    = '0;
            end
            default: begin
                n_tally = r_tally;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_alnum <= 1'b0;
            r_date_pend  <= 1'b0;
            r_line_alnum <= 1'b0;
            r_sent_word  <= 1'b0;
            r_win        <= {WIN_LEN{CH_FILL}};
            r_run_val    <= '0;
            r_in_run     <= 1'b0;
            r_tally      <= '0;
        end else if (i_en) begin
            r_prev_alnum <= n_prev_alnum;
            r_date_pend  <= n_date_pend;
            r_line_alnum <= n_line_alnum;
            r_sent_word  <= n_sent_word;
            r_win        <= n_win;
            r_run_val    <= n_run_val;
            r_in_run     <= n_in_run;
            r_tally      <= n_tally;
        end
    end

    assign o_tally_next = n_tally;
    assign o_tally_cur  = r_tally;

endmodule

`default_nettype wire
